// File: hdl/csfs_pkg.sv
// Shared types and constants of the crank spark and fuel scheduler.
package csfs_pkg;

   localparam int unsigned CSR_INDEX_BITS = 4;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam int unsigned ADVANCE_BITS = 32;
   localparam int unsigned SPARK_TICKS_BITS = 16;
   localparam int unsigned PERIOD_BITS = 16;
   localparam int unsigned FUEL_MASK_BITS = 4;
   localparam int unsigned PIN_BITS = 6;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ADVANCE = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARK = CSR_INDEX_BITS'(1);

   localparam logic [PIN_BITS-1:0] PIN_FRONT = 6'h01;
   localparam logic [PIN_BITS-1:0] PIN_REAR = 6'h02;
   localparam logic [PIN_BITS-1:0] PIN_CYL1 = 6'h04;
   localparam logic [PIN_BITS-1:0] PIN_CYL2 = 6'h08;
   localparam logic [PIN_BITS-1:0] PIN_CYL3 = 6'h10;
   localparam logic [PIN_BITS-1:0] PIN_CYL4 = 6'h20;
   localparam logic [PIN_BITS-1:0] PINS_SPARK = 6'h03;
   localparam logic [PIN_BITS-1:0] PINS_FUEL = 6'h3C;

   // Divisors applied to the captured tick count.
   localparam int unsigned US_SHIFT = 4;
   localparam int unsigned FUEL_DIVISOR = 800;
   localparam int unsigned FUEL_REM_BITS = $clog2(FUEL_DIVISOR);
   localparam logic [FUEL_REM_BITS-1:0] FUEL_REM_LAST = FUEL_REM_BITS'(FUEL_DIVISOR - 1);

   typedef struct packed {
      logic                      spark_front;
      logic                      spark_rear;
      logic [FUEL_MASK_BITS-1:0] fuel_mask;
      logic [PERIOD_BITS-1:0]    crank_period_us;
   } result_type;

endpackage

// File: hdl/csfs_req_if.sv
// Tick input channel of the crank spark and fuel scheduler.
interface csfs_req_if;
   logic valid;
   logic ready;
   logic crank_edge;

   modport source (output valid, output crank_edge, input ready);
   modport sink (input valid, input crank_edge, output ready);
endinterface

// File: hdl/csfs_rsp_if.sv
// Result channel of the crank spark and fuel scheduler.
interface csfs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                spark_front;
   logic                                spark_rear;
   logic [csfs_pkg::FUEL_MASK_BITS-1:0] fuel_mask;
   logic [csfs_pkg::PERIOD_BITS-1:0]    crank_period_us;

   modport source (output valid, output spark_front, output spark_rear, output fuel_mask,
                   output crank_period_us, input ready);
   modport sink (input valid, input spark_front, input spark_rear, input fuel_mask,
                 input crank_period_us, output ready);
endinterface

// File: hdl/csfs_csr_if.sv
// Register write channel of the crank spark and fuel scheduler.
interface csfs_csr_if;
   logic                                valid;
   logic                                ready;
   logic [csfs_pkg::CSR_INDEX_BITS-1:0] index;
   logic [csfs_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/crank_spark_fuel_scheduler.sv
// Crank-synchronous spark and fuel pulse scheduler for a four-cylinder, two-bank engine.
//
// Each request transaction is one timer tick, and one response transaction follows it
// with the pin levels and the last crank period after that tick. A tick is taken in
// every clock cycle while req_if.ready is high; its whole update is combinational logic
// into the state and result registers, and a response is offered from the output
// register. A two-entry output buffer keeps ticks flowing while a response waits, and
// requests stall only when both entries are full. The fuel length (captured ticks over
// 800) comes from a quotient and remainder pair that counts along with the elapsed tick
// counter, so no divider is needed. Register writes are taken in every cycle.
module crank_spark_fuel_scheduler #(
   parameter int unsigned COUNT_BITS = 32,
   parameter int unsigned SPARK_BITS = 16
) (
   input logic          clock,
   input logic          reset,
   csfs_req_if.sink     req_if,
   csfs_rsp_if.source   rsp_if,
   csfs_csr_if.sink     csr_if
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic [COUNT_BITS-1:0] advance_ff;
   logic [SPARK_BITS-1:0] spark_ticks_ff;

   logic [COUNT_BITS-1:0]              elapsed_ff, elapsed_in;
   logic [COUNT_BITS-1:0]              div_q_ff, div_q_in;
   logic [csfs_pkg::FUEL_REM_BITS-1:0] div_r_ff, div_r_in;
   logic [COUNT_BITS-1:0]              half_ff, half_in;
   logic [COUNT_BITS-1:0]              fuel_ticks_ff, fuel_ticks_in;
   logic [csfs_pkg::PERIOD_BITS-1:0]   period_ff, period_in;
   logic [COUNT_BITS-1:0]              event_cnt_ff, event_cnt_in;
   logic                               event_armed_ff, event_armed_in;
   logic                               at_top_ff, at_top_in;
   logic [SPARK_BITS-1:0]              spark_cnt_ff, spark_cnt_in;
   logic                               spark_run_ff, spark_run_in;
   logic [COUNT_BITS-1:0]              fuel_cnt_ff, fuel_cnt_in;
   logic                               fuel_run_ff, fuel_run_in;
   logic                               front_pick_ff, front_pick_in;
   logic                               rear_pick_ff, rear_pick_in;
   logic [csfs_pkg::PIN_BITS-1:0]      pins_ff, pins_in;

   logic [COUNT_BITS:0]   rearm_sum;
   logic [COUNT_BITS-1:0] rearm_ticks;
   logic [COUNT_BITS-1:0] period_full;

   csfs_pkg::result_type result;
   csfs_pkg::result_type out_ff, out_in;
   csfs_pkg::result_type skid_ff, skid_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;

   logic accept;
   logic deliver;

   assign req_if.ready = !skid_valid_ff;
   assign accept = req_if.valid && req_if.ready;
   assign deliver = out_valid_ff && rsp_if.ready;
   assign csr_if.ready = 1'b1;

   assign rearm_sum = {1'b0, half_ff} + {1'b0, advance_ff};
   assign rearm_ticks = rearm_sum[COUNT_BITS] ? COUNT_MAX : rearm_sum[COUNT_BITS-1:0];

   always_comb begin
      elapsed_in = elapsed_ff;
      div_q_in = div_q_ff;
      div_r_in = div_r_ff;
      half_in = half_ff;
      fuel_ticks_in = fuel_ticks_ff;
      period_in = period_ff;
      event_cnt_in = event_cnt_ff;
      event_armed_in = event_armed_ff;
      at_top_in = at_top_ff;
      spark_cnt_in = spark_cnt_ff;
      spark_run_in = spark_run_ff;
      fuel_cnt_in = fuel_cnt_ff;
      fuel_run_in = fuel_run_ff;
      front_pick_in = front_pick_ff;
      rear_pick_in = rear_pick_ff;
      pins_in = pins_ff;
      period_full = '0;

      if (elapsed_ff != COUNT_MAX) begin
         elapsed_in = elapsed_ff + 1'b1;
         if (div_r_ff == csfs_pkg::FUEL_REM_LAST) begin
            div_r_in = '0;
            div_q_in = div_q_ff + 1'b1;
         end else begin
            div_r_in = div_r_ff + 1'b1;
         end
      end

      if (spark_run_ff) begin
         if (spark_cnt_ff <= SPARK_BITS'(1)) begin
            spark_cnt_in = '0;
            spark_run_in = 1'b0;
            pins_in = pins_in & ~csfs_pkg::PINS_SPARK;
         end else begin
            spark_cnt_in = spark_cnt_ff - 1'b1;
         end
      end

      if (fuel_run_ff) begin
         if (fuel_cnt_ff <= COUNT_BITS'(1)) begin
            fuel_cnt_in = '0;
            fuel_run_in = 1'b0;
            pins_in = pins_in & ~csfs_pkg::PINS_FUEL;
         end else begin
            fuel_cnt_in = fuel_cnt_ff - 1'b1;
         end
      end

      if (event_armed_ff) begin
         if (event_cnt_ff <= COUNT_BITS'(1)) begin
            event_cnt_in = '0;
            event_armed_in = 1'b0;
            spark_cnt_in = spark_ticks_ff;
            spark_run_in = 1'b1;
            fuel_cnt_in = fuel_ticks_ff;
            fuel_run_in = 1'b1;
            if (at_top_ff) begin
               pins_in = pins_in | csfs_pkg::PIN_FRONT
                         | (front_pick_ff ? csfs_pkg::PIN_CYL3 : csfs_pkg::PIN_CYL1);
               front_pick_in = !front_pick_ff;
               at_top_in = 1'b0;
               event_cnt_in = rearm_ticks;
               event_armed_in = 1'b1;
            end else begin
               pins_in = pins_in | csfs_pkg::PIN_REAR
                         | (rear_pick_ff ? csfs_pkg::PIN_CYL4 : csfs_pkg::PIN_CYL2);
               rear_pick_in = !rear_pick_ff;
            end
         end else begin
            event_cnt_in = event_cnt_ff - 1'b1;
         end
      end

      if (req_if.crank_edge) begin
         period_full = elapsed_in >> csfs_pkg::US_SHIFT;
         if ((period_full >> csfs_pkg::PERIOD_BITS) != '0) begin
            period_in = {csfs_pkg::PERIOD_BITS{1'b1}};
         end else begin
            period_in = period_full[csfs_pkg::PERIOD_BITS-1:0];
         end
         half_in = elapsed_in >> 1;
         fuel_ticks_in = div_q_in;
         elapsed_in = '0;
         div_q_in = '0;
         div_r_in = '0;
         at_top_in = 1'b1;
         event_cnt_in = advance_ff;
         event_armed_in = 1'b1;
      end
   end

   always_comb begin
      result.spark_front = pins_in[0];
      result.spark_rear = pins_in[1];
      result.fuel_mask = pins_in[csfs_pkg::PIN_BITS-1:2];
      result.crank_period_us = period_in;

      out_in = out_ff;
      skid_in = skid_ff;
      out_valid_in = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff) begin
         out_in = result;
         out_valid_in = accept;
      end else if (skid_valid_ff) begin
         if (deliver) begin
            out_in = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (deliver) begin
         out_in = result;
         out_valid_in = accept;
      end else if (accept) begin
         skid_in = result;
         skid_valid_in = 1'b1;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.spark_front = out_ff.spark_front;
   assign rsp_if.spark_rear = out_ff.spark_rear;
   assign rsp_if.fuel_mask = out_ff.fuel_mask;
   assign rsp_if.crank_period_us = out_ff.crank_period_us;

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         advance_ff <= '0;
         spark_ticks_ff <= SPARK_BITS'(1);
      end else if (csr_if.valid) begin
         case (csr_if.index)
            csfs_pkg::CSR_ADVANCE: begin
               advance_ff <= COUNT_BITS'(csr_if.data[csfs_pkg::ADVANCE_BITS-1:0]);
            end
            csfs_pkg::CSR_SPARK: begin
               spark_ticks_ff <= SPARK_BITS'(csr_if.data[csfs_pkg::SPARK_TICKS_BITS-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         div_q_ff <= '0;
         div_r_ff <= '0;
         half_ff <= '0;
         fuel_ticks_ff <= COUNT_BITS'(1);
         period_ff <= '0;
         event_cnt_ff <= '0;
         event_armed_ff <= 1'b0;
         at_top_ff <= 1'b1;
         spark_cnt_ff <= '0;
         spark_run_ff <= 1'b0;
         fuel_cnt_ff <= '0;
         fuel_run_ff <= 1'b0;
         front_pick_ff <= 1'b0;
         rear_pick_ff <= 1'b0;
         pins_ff <= '0;
      end else if (accept) begin
         elapsed_ff <= elapsed_in;
         div_q_ff <= div_q_in;
         div_r_ff <= div_r_in;
         half_ff <= half_in;
         fuel_ticks_ff <= fuel_ticks_in;
         period_ff <= period_in;
         event_cnt_ff <= event_cnt_in;
         event_armed_ff <= event_armed_in;
         at_top_ff <= at_top_in;
         spark_cnt_ff <= spark_cnt_in;
         spark_run_ff <= spark_run_in;
         fuel_cnt_ff <= fuel_cnt_in;
         fuel_run_ff <= fuel_run_in;
         front_pick_ff <= front_pick_in;
         rear_pick_ff <= rear_pick_in;
         pins_ff <= pins_in;
      end
   end

endmodule
